// ===== rtl/deq_pkg.sv =====
// Shared types, constants and ring arithmetic for the double-ended queue.
package deq_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DUMP       = 3'd4
  } deq_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } deq_status_t;

  typedef struct packed {
    logic [2:0]               operation;
    logic signed [DATA_W-1:0] value;
  } deq_req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] result_value;
    logic                     last;
  } deq_rsp_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } deq_mem_req_t;

  // (base + offset) mod CAPACITY, both operands already below CAPACITY
  function automatic logic [ADDR_W-1:0] ring_add(logic [ADDR_W-1:0] base,
                                                 logic [ADDR_W-1:0] offset);
    logic [ADDR_W:0] sum;
    sum = {1'b0, base} + {1'b0, offset};
    if (sum >= (ADDR_W + 1)'(CAPACITY)) begin
      sum = sum - (ADDR_W + 1)'(CAPACITY);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

// ===== rtl/deq_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
module deq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/deq_ctrl.sv =====
// Request sequencer: decodes operations, keeps front/count, drives the RAM.
module deq_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  deq_pkg::deq_req_t               req,
  output deq_pkg::deq_mem_req_t           mem_req,
  input  logic signed [deq_pkg::DATA_W-1:0] rdata,
  output logic                            res_valid,
  input  logic                            res_ready,
  output deq_pkg::deq_rsp_t               res
);
  import deq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_WAIT = 3'b100
  } state_t;

  state_t            state, state_next;
  logic [ADDR_W-1:0] front, front_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [ADDR_W-1:0] idx, idx_next;
  logic              is_dump, is_dump_next;
  deq_rsp_t          pend, pend_next;

  logic              full, empty, rd_last;
  logic [ADDR_W-1:0] idx_inc;

  assign full    = (count == CNT_W'(CAPACITY));
  assign empty   = (count == '0);
  assign idx_inc = idx + ADDR_W'(1);
  // dump is finished when the entry just read was the back one
  assign rd_last = !is_dump || ({1'b0, idx} + CNT_W'(1) == count);

  always_comb begin
    state_next   = state;
    front_next   = front;
    count_next   = count;
    idx_next     = idx;
    is_dump_next = is_dump;
    pend_next    = pend;
    mem_req      = '0;
    req_ready    = (state == S_IDLE);
    res_valid    = 1'b0;
    res          = '0;

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          case (deq_op_t'(req.operation))
            OP_PUSH_FRONT: begin
              state_next = S_WAIT;
              if (full) begin
                pend_next = '{status: ST_FULL, result_value: '0, last: 1'b1};
              end else begin
                front_next    = ring_add(front, ADDR_W'(CAPACITY - 1));
                mem_req.we    = 1'b1;
                mem_req.waddr = ring_add(front, ADDR_W'(CAPACITY - 1));
                mem_req.wdata = req.value;
                count_next    = count + CNT_W'(1);
                pend_next     = '{status: ST_OK, result_value: '0, last: 1'b1};
              end
            end
            OP_PUSH_BACK: begin
              state_next = S_WAIT;
              if (full) begin
                pend_next = '{status: ST_FULL, result_value: '0, last: 1'b1};
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ring_add(front, count[ADDR_W-1:0]);
                mem_req.wdata = req.value;
                count_next    = count + CNT_W'(1);
                pend_next     = '{status: ST_OK, result_value: '0, last: 1'b1};
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                pend_next  = '{status: ST_EMPTY, result_value: '0, last: 1'b1};
                state_next = S_WAIT;
              end else begin
                mem_req.re   = 1'b1;
                mem_req.raddr = front;
                front_next   = ring_add(front, ADDR_W'(1));
                count_next   = count - CNT_W'(1);
                is_dump_next = 1'b0;
                state_next   = S_READ;
              end
            end
            OP_POP_BACK: begin
              if (empty) begin
                pend_next  = '{status: ST_EMPTY, result_value: '0, last: 1'b1};
                state_next = S_WAIT;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = ring_add(front, ADDR_W'(count - CNT_W'(1)));
                count_next    = count - CNT_W'(1);
                is_dump_next  = 1'b0;
                state_next    = S_READ;
              end
            end
            OP_DUMP: begin
              if (empty) begin
                pend_next  = '{status: ST_EMPTY, result_value: '0, last: 1'b1};
                state_next = S_WAIT;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = front;
                idx_next      = '0;
                is_dump_next  = 1'b1;
                state_next    = S_READ;
              end
            end
            default: begin
              // unused opcodes are dropped silently
            end
          endcase
        end
      end
      S_READ: begin
        res_valid = 1'b1;
        res       = '{status: ST_OK, result_value: rdata, last: rd_last};
        if (res_ready) begin
          if (rd_last) begin
            state_next = S_IDLE;
          end else begin
            idx_next      = idx_inc;
            mem_req.re    = 1'b1;
            mem_req.raddr = ring_add(front, idx_inc);
          end
        end else begin
          // RAM data is only good for this cycle; park it
          pend_next  = res;
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        res_valid = 1'b1;
        res       = pend;
        if (res_ready) begin
          if (pend.last) begin
            state_next = S_IDLE;
          end else begin
            idx_next      = idx_inc;
            mem_req.re    = 1'b1;
            mem_req.raddr = ring_add(front, idx_inc);
            state_next    = S_READ;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      front   <= '0;
      count   <= '0;
      is_dump <= 1'b0;
    end else begin
      state   <= state_next;
      front   <= front_next;
      count   <= count_next;
      is_dump <= is_dump_next;
    end
  end

  always_ff @(posedge clk) begin
    idx  <= idx_next;
    pend <= pend_next;
  end

endmodule

// ===== rtl/double_ended_queue.sv =====
// Top level of the bounded double-ended queue: sequencer, entry RAM, output register.
//
// Usage:
//   Requests enter on req_valid/req_ready with req.operation and req.value.
//   Responses leave on rsp_valid/rsp_ready with status, result_value, last.
//   Push and pop requests give one response; dump gives one response per
//   stored entry, front to back, with last on the back entry (one EMPTY
//   response when the queue is empty). Unused opcodes give no response.
// Timing:
//   A push takes its response through the pending register into the output
//   register; a pop's registered RAM read data goes to the output register.
//   A dump makes one RAM read per entry, each with registered read data.
//   A new request is taken once the previous one has handed its last
//   response to the output register.
// Reset:
//   Synchronous rst empties the queue (front and count cleared). The entry
//   RAM keeps its contents; only live entries are ever read.
// Stall:
//   While rsp_ready is low the output register holds its response and the
//   sequencer parks one more in its pending register, then waits.
module double_ended_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  deq_pkg::deq_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output deq_pkg::deq_rsp_t rsp
);
  import deq_pkg::*;

  deq_mem_req_t      mem_req;
  logic [DATA_W-1:0] rdata;
  logic              res_valid;
  logic              res_ready;
  deq_rsp_t          res;

  assign res_ready = !rsp_valid || rsp_ready;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .mem_req   (mem_req),
    .rdata     (rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // writes and reads never hit the RAM in the same cycle: pushes happen
  // only on accept, reads only for pops and dumps
  deq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      rsp <= res;
    end
  end

endmodule

// ===== rtl/deq_check.sv =====
// Port-level checker for the double-ended queue, bound to the top level.
module deq_check (
  input logic              clk,
  input logic              rst,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input deq_pkg::deq_rsp_t rsp
);
  import deq_pkg::*;

  // after reset the queue is idle with nothing to deliver
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!rsp_valid && req_ready))
    else $error("not idle after reset");

  // only a dump produces non-final responses, and those are always OK
  a_nonlast_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.last) |-> (rsp.status == ST_OK))
    else $error("non-final response with error status");

  // failed operations carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_OK) |-> (rsp.result_value == '0))
    else $error("error response with nonzero value");

  // the back entry of a dump has not left the sequencer yet, so it stays busy
  a_dump_busy: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.last) |-> !req_ready)
    else $error("request taken in the middle of a dump");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("response changed while stalled");

endmodule

bind double_ended_queue deq_check u_check (.*);
